// File: design/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared widths, types and arithmetic steps of the airfoil level-set evaluator
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int FRAC = 16;
  localparam int XW = 17;
  localparam int YW = 18;
  localparam int CW = 20;
  localparam int NCOEF = 5;
  localparam int LW = 23;
  localparam int GW = 32;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // square root: two radicand bits per stage
  localparam int SqSteps = (XW + FRAC + 1) / 2;
  localparam int RW = 2 * SqSteps;
  localparam int SQW = SqSteps;
  localparam int REMW = SQW + 2;

  // successive powers of x
  localparam int P2W = 2 * XW - FRAC;
  localparam int P3W = 3 * XW - 2 * FRAC;
  localparam int P4W = 4 * XW - 3 * FRAC;

  // product and accumulator widths
  localparam int TW = 44;
  localparam int AW = 40;

  // divider: dividend is |c0| shifted up, divisor is twice the root
  localparam int NW = CW + FRAC;
  localparam int DW = SQW + 1;

  localparam logic signed [AW-1:0] LvlMax = AW'((longint'(1) <<< (LW - 1)) - 1);
  localparam logic signed [AW-1:0] LvlMin = AW'(-(longint'(1) <<< (LW - 1)));
  localparam logic signed [AW-1:0] GrdMax = AW'((longint'(1) <<< (GW - 1)) - 1);
  localparam logic signed [AW-1:0] GrdMin = AW'(-(longint'(1) <<< (GW - 1)));

  typedef enum logic [2:0] {
    REG_SQRT   = 3'd0,
    REG_LIN    = 3'd1,
    REG_SQUARE = 3'd2,
    REG_CUBE   = 3'd3,
    REG_QUART  = 3'd4
  } ale_reg_e;

  typedef struct packed {
    logic signed [CW-1:0] c0;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic signed [CW-1:0] c3;
    logic signed [CW-1:0] c4;
  } ale_coef_t;

  typedef struct packed {
    logic [XW-1:0]        x;
    logic signed [YW-1:0] y;
  } ale_sq_side_t;

  typedef struct packed {
    logic signed [YW-1:0] y;
    logic signed [TW-1:0] t4;
    logic signed [AW-1:0] dpart;
    logic signed [AW-1:0] gpart;
    logic                 x_zero;
  } ale_div_side_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [SQW-1:0]  root;
  } ale_sq_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [NW-1:0] nq;
  } ale_dv_t;

  // floor of a product back to FRAC fraction bits
  function automatic logic signed [AW-1:0] fl(logic signed [TW-1:0] t);
    return AW'(t >>> FRAC);
  endfunction

  // one digit of the restoring square root
  function automatic ale_sq_t sq_step(ale_sq_t cur, logic [1:0] pair);
    ale_sq_t         nxt;
    logic [REMW-1:0] sh;
    logic [REMW-1:0] trial;
    sh    = {cur.rem[REMW-3:0], pair};
    trial = {cur.root, 2'b01};
    if (sh >= trial) begin
      nxt.rem  = sh - trial;
      nxt.root = {cur.root[SQW-2:0], 1'b1};
    end else begin
      nxt.rem  = sh;
      nxt.root = {cur.root[SQW-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // one quotient bit of the restoring divider
  function automatic ale_dv_t dv_step(ale_dv_t cur, logic [DW-1:0] den);
    ale_dv_t     nxt;
    logic [DW:0] sh;
    sh = {cur.rem, cur.nq[NW-1]};
    if (sh >= {1'b0, den}) begin
      nxt.rem = DW'(sh - {1'b0, den});
      nxt.nq  = {cur.nq[NW-2:0], 1'b1};
    end else begin
      nxt.rem = DW'(sh);
      nxt.nq  = {cur.nq[NW-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// File: design/ale_sqrt.sv
// ----------------------------------------------------------------------------
// ale_sqrt
// Pipelined integer square root of x shifted up by the fraction bits
// ----------------------------------------------------------------------------
module ale_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  ale_pkg::ale_sq_side_t side_i,
  output logic                  valid_o,
  output ale_pkg::ale_sq_side_t side_o,
  output logic [ale_pkg::SQW-1:0] root_o
);
  import ale_pkg::*;

  logic         vld_q  [SqSteps];
  ale_sq_side_t side_q [SqSteps];
  logic [RW-1:0] rad_q [SqSteps];
  ale_sq_t      st_q   [SqSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqSteps; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < SqSteps; k++) begin
        if (k == 0) begin
          vld_q[k]  <= valid_i;
          side_q[k] <= side_i;
          rad_q[k]  <= RW'({side_i.x, {FRAC{1'b0}}, 2'b00});
          st_q[k]   <= sq_step('0, 2'(RW'({side_i.x, {FRAC{1'b0}}}) >> (RW - 2)));
        end else begin
          vld_q[k]  <= vld_q[k-1];
          side_q[k] <= side_q[k-1];
          rad_q[k]  <= {rad_q[k-1][RW-3:0], 2'b00};
          st_q[k]   <= sq_step(st_q[k-1], rad_q[k-1][RW-1 -: 2]);
        end
      end
    end
  end

  assign valid_o = vld_q[SqSteps-1];
  assign side_o  = side_q[SqSteps-1];
  assign root_o  = st_q[SqSteps-1].root;

endmodule

// File: design/ale_poly.sv
// ----------------------------------------------------------------------------
// ale_poly
// Five-stage power and coefficient product pipeline with partial sums
// ----------------------------------------------------------------------------
module ale_poly (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ale_pkg::ale_coef_t     coef_i,
  input  logic                   valid_i,
  input  ale_pkg::ale_sq_side_t  side_i,
  input  logic [ale_pkg::SQW-1:0] root_i,
  output logic                   valid_o,
  output ale_pkg::ale_div_side_t side_o,
  output logic [ale_pkg::DW-1:0] den_o
);
  import ale_pkg::*;

  logic signed [CW+1:0] c2x2, c3x3, c4x4;

  logic [4:0] vld_q;

  // stage 1
  logic [XW-1:0]        x1_q;
  logic signed [YW-1:0] y1_q;
  logic [SQW-1:0]       s1_q;
  logic                 z1_q;
  logic [2*XW-1:0]      xx1_q;
  logic signed [TW-1:0] t0_1_q, t1_1_q;
  // stage 2
  logic [XW-1:0]        x2_q;
  logic signed [YW-1:0] y2_q;
  logic [SQW-1:0]       s2_q;
  logic                 z2_q;
  logic [P2W-1:0]       p2_2_q;
  logic [P2W+XW-1:0]    m3_2_q;
  logic signed [TW-1:0] t0_2_q, t1_2_q, g2_2_q;
  // stage 3
  logic signed [YW-1:0] y3_q;
  logic [SQW-1:0]       s3_q;
  logic                 z3_q;
  logic [P3W-1:0]       p3_3_q;
  logic [P3W+XW-1:0]    m4_3_q;
  logic signed [TW-1:0] t2_3_q, g3_3_q;
  logic signed [AW-1:0] d3_q, g3s_q;
  // stage 4
  logic signed [YW-1:0] y4_q;
  logic [SQW-1:0]       s4_q;
  logic                 z4_q;
  logic [P4W-1:0]       p4_4_q;
  logic signed [TW-1:0] t3_4_q, g4_4_q;
  logic signed [AW-1:0] d4_q, g4s_q;
  // stage 5
  logic signed [YW-1:0] y5_q;
  logic [SQW-1:0]       s5_q;
  logic                 z5_q;
  logic signed [TW-1:0] t4_5_q;
  logic signed [AW-1:0] d5_q, g5s_q;

  assign c2x2 = (CW+2)'(coef_i.c2) <<< 1;
  assign c3x3 = ((CW+2)'(coef_i.c3) <<< 1) + (CW+2)'(coef_i.c3);
  assign c4x4 = (CW+2)'(coef_i.c4) <<< 2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};

      x1_q   <= side_i.x;
      y1_q   <= side_i.y;
      s1_q   <= root_i;
      z1_q   <= (side_i.x == '0);
      xx1_q  <= (2*XW)'(side_i.x) * (2*XW)'(side_i.x);
      t0_1_q <= TW'(coef_i.c0) * TW'($signed({1'b0, root_i}));
      t1_1_q <= TW'(coef_i.c1) * TW'($signed({1'b0, side_i.x}));

      x2_q   <= x1_q;
      y2_q   <= y1_q;
      s2_q   <= s1_q;
      z2_q   <= z1_q;
      p2_2_q <= P2W'(xx1_q >> FRAC);
      m3_2_q <= (P2W+XW)'(P2W'(xx1_q >> FRAC)) * (P2W+XW)'(x1_q);
      t0_2_q <= t0_1_q;
      t1_2_q <= t1_1_q;
      g2_2_q <= TW'(c2x2) * TW'($signed({1'b0, x1_q}));

      y3_q   <= y2_q;
      s3_q   <= s2_q;
      z3_q   <= z2_q;
      p3_3_q <= P3W'(m3_2_q >> FRAC);
      m4_3_q <= (P3W+XW)'(P3W'(m3_2_q >> FRAC)) * (P3W+XW)'(x2_q);
      t2_3_q <= TW'(coef_i.c2) * TW'($signed({1'b0, p2_2_q}));
      g3_3_q <= TW'(c3x3) * TW'($signed({1'b0, p2_2_q}));
      d3_q   <= fl(t0_2_q) + fl(t1_2_q);
      g3s_q  <= AW'(coef_i.c1) + fl(g2_2_q);

      y4_q   <= y3_q;
      s4_q   <= s3_q;
      z4_q   <= z3_q;
      p4_4_q <= P4W'(m4_3_q >> FRAC);
      t3_4_q <= TW'(coef_i.c3) * TW'($signed({1'b0, p3_3_q}));
      g4_4_q <= TW'(c4x4) * TW'($signed({1'b0, p3_3_q}));
      d4_q   <= d3_q + fl(t2_3_q);
      g4s_q  <= g3s_q + fl(g3_3_q);

      y5_q   <= y4_q;
      s5_q   <= s4_q;
      z5_q   <= z4_q;
      t4_5_q <= TW'(coef_i.c4) * TW'($signed({1'b0, p4_4_q}));
      d5_q   <= d4_q + fl(t3_4_q);
      g5s_q  <= g4s_q + fl(g4_4_q);
    end
  end

  assign valid_o       = vld_q[4];
  assign side_o.y      = y5_q;
  assign side_o.t4     = t4_5_q;
  assign side_o.dpart  = d5_q;
  assign side_o.gpart  = g5s_q;
  assign side_o.x_zero = z5_q;
  assign den_o         = {s5_q, 1'b0};

endmodule

// File: design/ale_div.sv
// ----------------------------------------------------------------------------
// ale_div
// Pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ale_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  ale_pkg::ale_div_side_t side_i,
  input  logic [ale_pkg::NW-1:0] num_i,
  input  logic [ale_pkg::DW-1:0] den_i,
  output logic                   valid_o,
  output ale_pkg::ale_div_side_t side_o,
  output logic [ale_pkg::NW-1:0] quo_o
);
  import ale_pkg::*;

  logic          vld_q  [NW];
  ale_div_side_t side_q [NW];
  logic [DW-1:0] den_q  [NW];
  ale_dv_t       st_q   [NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < NW; k++) begin
        if (k == 0) begin
          vld_q[k]  <= valid_i;
          side_q[k] <= side_i;
          den_q[k]  <= den_i;
          st_q[k]   <= dv_step({{DW{1'b0}}, num_i}, den_i);
        end else begin
          vld_q[k]  <= vld_q[k-1];
          side_q[k] <= side_q[k-1];
          den_q[k]  <= den_q[k-1];
          st_q[k]   <= dv_step(st_q[k-1], den_q[k-1]);
        end
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign side_o  = side_q[NW-1];
  assign quo_o   = st_q[NW-1].nq;

endmodule

// File: design/airfoil_level_set_eval.sv
// ----------------------------------------------------------------------------
// airfoil_level_set_eval
// Fixed-point level set and x-gradient of a four-digit airfoil thickness curve
// ----------------------------------------------------------------------------
// One point (x_pos_i, y_pos_i) is transferred when in_valid_i is high and
// in_stall_o is low; one result is transferred when out_valid_o is high and
// out_stall_i is low. Each point gives exactly one result, in order.
// Coefficients sit in five registers on the APB port at byte addresses 0 to
// 16; the user must write them only while the block is idle, as the block
// itself does not enforce this. Throughput is one point per cycle while no
// held result stalls the pipeline. There are 17 square-root stages (one root
// bit each), 5 power and product stages, 36 divider stages (one quotient bit
// each) for the c0/sqrt term, and the output register with sum and saturation.
// The whole pipeline advances on one enable; while a result waits under
// out_stall_i every stage holds and in_stall_o is high, nothing is dropped.
// Reset clears the valid bits of all stages and the coefficient registers.
// ----------------------------------------------------------------------------
module airfoil_level_set_eval (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ale_pkg::AddrW-1:0]  paddr,
  input  logic [ale_pkg::DataW-1:0]  pwdata,
  output logic [ale_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ale_pkg::XW-1:0]     x_pos_i,
  input  logic signed [ale_pkg::YW-1:0] y_pos_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [ale_pkg::LW-1:0] level_value_o,
  output logic signed [ale_pkg::GW-1:0] grad_x_o,
  output logic                       grad_x_saturated_o,
  output logic                       grad_y_negative_o
);
  import ale_pkg::*;

  logic [CW-1:0] coef_q [NCOEF];
  ale_reg_e      reg_sel;
  logic          wr_en;
  ale_coef_t     coef;
  logic          adv;

  ale_sq_side_t  sq_side_in, sq_side;
  logic          sq_valid;
  logic [SQW-1:0] root;
  logic          pl_valid;
  ale_div_side_t pl_side, dv_side;
  logic [DW-1:0] den;
  logic [NW-1:0] num;
  logic          dv_valid;
  logic [NW-1:0] quo;

  logic signed [AW-1:0] d_sum, abs_y, lvl, q_s, g_sum;
  logic [CW-1:0]        c0_mag;

  logic                 out_valid_q;
  logic signed [LW-1:0] level_d, level_q;
  logic signed [GW-1:0] grad_d, grad_q;
  logic                 gsat_d, gsat_q, gyneg_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = ale_reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NCOEF; k++) coef_q[k] <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SQRT:   coef_q[REG_SQRT]   <= pwdata[CW-1:0];
        REG_LIN:    coef_q[REG_LIN]    <= pwdata[CW-1:0];
        REG_SQUARE: coef_q[REG_SQUARE] <= pwdata[CW-1:0];
        REG_CUBE:   coef_q[REG_CUBE]   <= pwdata[CW-1:0];
        REG_QUART:  coef_q[REG_QUART]  <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SQRT:   prdata = DataW'(coef_q[REG_SQRT]);
      REG_LIN:    prdata = DataW'(coef_q[REG_LIN]);
      REG_SQUARE: prdata = DataW'(coef_q[REG_SQUARE]);
      REG_CUBE:   prdata = DataW'(coef_q[REG_CUBE]);
      REG_QUART:  prdata = DataW'(coef_q[REG_QUART]);
      default:    prdata = '0;
    endcase
  end

  assign coef.c0 = $signed(coef_q[REG_SQRT]);
  assign coef.c1 = $signed(coef_q[REG_LIN]);
  assign coef.c2 = $signed(coef_q[REG_SQUARE]);
  assign coef.c3 = $signed(coef_q[REG_CUBE]);
  assign coef.c4 = $signed(coef_q[REG_QUART]);

  // every stage moves together unless a result is held
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign sq_side_in.x = x_pos_i;
  assign sq_side_in.y = y_pos_i;

  ale_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .root_o  (root)
  );

  ale_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .coef_i  (coef),
    .valid_i (sq_valid),
    .side_i  (sq_side),
    .root_i  (root),
    .valid_o (pl_valid),
    .side_o  (pl_side),
    .den_o   (den)
  );

  assign c0_mag = coef.c0[CW-1] ? CW'(-coef.c0) : CW'(coef.c0);
  assign num    = {c0_mag, {FRAC{1'b0}}};

  ale_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pl_valid),
    .side_i  (pl_side),
    .num_i   (num),
    .den_i   (den),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_o   (quo)
  );

  // final sums and saturation
  always_comb begin
    d_sum = dv_side.dpart + fl(dv_side.t4);
    abs_y = dv_side.y[YW-1] ? -AW'(dv_side.y) : AW'(dv_side.y);
    lvl   = d_sum - abs_y;
    if (lvl > LvlMax)      level_d = LW'(LvlMax);
    else if (lvl < LvlMin) level_d = LW'(LvlMin);
    else                   level_d = LW'(lvl);

    q_s   = coef.c0[CW-1] ? -AW'(quo) : AW'(quo);
    g_sum = q_s + dv_side.gpart;
    if (dv_side.x_zero) begin
      grad_d = coef.c0[CW-1] ? GW'(GrdMin) : GW'(GrdMax);
      gsat_d = 1'b1;
    end else if (g_sum > GrdMax) begin
      grad_d = GW'(GrdMax);
      gsat_d = 1'b1;
    end else if (g_sum < GrdMin) begin
      grad_d = GW'(GrdMin);
      gsat_d = 1'b1;
    end else begin
      grad_d = GW'(g_sum);
      gsat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
      level_q     <= level_d;
      grad_q      <= grad_d;
      gsat_q      <= gsat_d;
      gyneg_q     <= !dv_side.y[YW-1];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign level_value_o      = level_q;
  assign grad_x_o           = grad_q;
  assign grad_x_saturated_o = gsat_q;
  assign grad_y_negative_o  = gyneg_q;

  // a held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(level_value_o) && $stable(grad_x_o))
    else $error("held result changed");

  // a clipped gradient sits at one of the two rails
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grad_x_saturated_o |->
      (grad_x_o == 32'h7fffffff || grad_x_o == 32'h80000000))
    else $error("saturated gradient off the rails");

  // an unclipped gradient is checked to lie within half of the range
  a_unsat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !grad_x_saturated_o |-> grad_x_o[GW-1] == grad_x_o[GW-2])
    else $error("unclipped gradient near the rails");

endmodule
